>>> rtl/ttgc_pkg.sv
// Shared types, codes and the gate classification function for the truth table classifier.
package ttgc_pkg;

   // Gate codes reported on the result channel.
   typedef enum logic [3:0] {
      GT_C0   = 4'd0,
      GT_C1   = 4'd1,
      GT_BUF  = 4'd2,
      GT_NOT  = 4'd3,
      GT_AND  = 4'd4,
      GT_OR   = 4'd5,
      GT_NAND = 4'd6,
      GT_NOR  = 4'd7,
      GT_XOR  = 4'd8,
      GT_XNOR = 4'd9,
      GT_NONE = 4'd10
   } gate_code_type;

   localparam int unsigned NUM_INPUTS_W = 4;

   // One table bit as held in the input register.
   typedef struct packed {
      logic [NUM_INPUTS_W-1:0] num_inputs;
      logic                    truth_bit;
   } item_type;

   // What the classifier tells the control logic about the held item.
   typedef struct packed {
      logic          last;
      gate_code_type gate_type;
   } result_type;

   // Classifies a finished table from its input count, end values and flags.
   function automatic gate_code_type classify(
      input logic [NUM_INPUTS_W-1:0] n,
      input logic                    v0,
      input logic                    v1,
      input logic                    mid_zero,
      input logic                    mid_one,
      input logic                    xor_ok,
      input logic                    xnor_ok
   );
      gate_code_type code;
      code = GT_NONE;
      if (n == '0) begin
         code = v1 ? GT_C1 : GT_C0;
      end else if (n == NUM_INPUTS_W'(1)) begin
         if (!v0 && v1) begin
            code = GT_BUF;
         end else if (v0 && !v1) begin
            code = GT_NOT;
         end else begin
            code = GT_NONE;
         end
      end else if (!v0 && v1 && !mid_zero) begin
         code = GT_OR;
      end else if (!v0 && v1 && !mid_one) begin
         code = GT_AND;
      end else if (v0 && !v1 && !mid_zero) begin
         code = GT_NAND;
      end else if (v0 && !v1 && !mid_one) begin
         code = GT_NOR;
      end else if (xor_ok) begin
         code = GT_XOR;
      end else if (xnor_ok) begin
         code = GT_XNOR;
      end else begin
         code = GT_NONE;
      end
      return code;
   endfunction

endpackage

>>> rtl/ttgc_if.sv
// Valid/ready channel interfaces for table bits and gate results.
interface ttgc_req_if;
   logic                                valid;
   logic                                ready;
   logic [ttgc_pkg::NUM_INPUTS_W-1:0]   num_inputs;
   logic                                truth_bit;

   modport source (output valid, output num_inputs, output truth_bit, input ready);
   modport sink (input valid, input num_inputs, input truth_bit, output ready);
endinterface

interface ttgc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] gate_type;

   modport source (output valid, output gate_type, input ready);
   modport sink (input valid, input gate_type, output ready);
endinterface

>>> rtl/ttgc_in_stage.sv
// Input register that holds one table bit until the classifier consumes it.
module ttgc_in_stage (
   input  logic               clock,
   input  logic               reset,
   ttgc_req_if.sink           req_chan,
   input  logic               advance,
   output logic               hold_valid,
   output ttgc_pkg::item_type hold_item
);

   logic               valid_ff;
   logic               valid_in;
   ttgc_pkg::item_type item_ff;
   logic               accept;

   // The register takes a new item when it is empty or its item moves on this cycle.
   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign valid_in       = accept || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.num_inputs <= req_chan.num_inputs;
         item_ff.truth_bit  <= req_chan.truth_bit;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

>>> rtl/ttgc_classify.sv
// Table state and flag update with classification of the held bit.
module ttgc_classify #(
   parameter int MAX_INPUTS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ttgc_pkg::item_type   hold_item,
   input  logic                 advance,
   output ttgc_pkg::result_type result
);

   localparam int NW = ttgc_pkg::NUM_INPUTS_W;

   logic [MAX_INPUTS-1:0] pos_ff, pos_in;
   logic [NW-1:0]         n_ff, n_in;
   logic                  first_ff, first_in;
   logic                  mid_zero_ff, mid_zero_in;
   logic                  mid_one_ff, mid_one_in;
   logic                  xor_ok_ff, xor_ok_in;
   logic                  xnor_ok_ff, xnor_ok_in;

   logic                  at_first;
   logic [NW-1:0]         n_sat;
   logic [MAX_INPUTS-1:0] last_pos;
   logic                  at_last;
   logic                  in_middle;
   logic                  parity;
   logic                  bit_val;

   assign bit_val  = hold_item.truth_bit;
   assign at_first = (pos_ff == '0);

   // The input count is clipped to the largest supported table.
   assign n_sat = (int'(hold_item.num_inputs) > MAX_INPUTS) ? NW'(MAX_INPUTS)
                                                             : hold_item.num_inputs;
   assign n_in  = at_first ? n_sat : n_ff;

   // The last minterm index has its low n bits set.
   always_comb begin
      for (int i = 0; i < MAX_INPUTS; i++) begin
         last_pos[i] = (i < int'(n_in));
      end
   end

   assign at_last   = (pos_ff == last_pos);
   assign in_middle = !at_first && !at_last;
   assign parity    = ^pos_ff;

   // Flags restart on the first bit of every table.
   assign first_in    = at_first ? bit_val : first_ff;
   assign mid_zero_in = (!at_first && mid_zero_ff) || (in_middle && !bit_val);
   assign mid_one_in  = (!at_first && mid_one_ff) || (in_middle && bit_val);
   assign xor_ok_in   = (at_first || xor_ok_ff) && (bit_val == parity);
   assign xnor_ok_in  = (at_first || xnor_ok_ff) && (bit_val != parity);
   assign pos_in      = at_last ? '0 : pos_ff + MAX_INPUTS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         n_ff        <= '0;
         first_ff    <= 1'b0;
         mid_zero_ff <= 1'b0;
         mid_one_ff  <= 1'b0;
         xor_ok_ff   <= 1'b1;
         xnor_ok_ff  <= 1'b1;
      end else if (advance) begin
         pos_ff      <= pos_in;
         n_ff        <= n_in;
         first_ff    <= first_in;
         mid_zero_ff <= mid_zero_in;
         mid_one_ff  <= mid_one_in;
         xor_ok_ff   <= xor_ok_in;
         xnor_ok_ff  <= xnor_ok_in;
      end
   end

   // The code is only meaningful when the held bit ends its table.
   assign result.last      = at_last;
   assign result.gate_type = ttgc_pkg::classify(n_in, first_in, bit_val, mid_zero_in,
                                                mid_one_in, xor_ok_in, xnor_ok_in);

endmodule

>>> rtl/ttgc_out_reg.sv
// Result register that presents one gate code on the result channel.
module ttgc_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  ttgc_pkg::gate_code_type gate_type,
   ttgc_rsp_if.source              rsp_chan,
   output logic                    out_free
);

   logic       valid_ff;
   logic       valid_in;
   logic [3:0] code_ff;

   // The register can take a new result when empty or when its result is taken now.
   assign out_free = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= gate_type;
      end
   end

   assign rsp_chan.valid     = valid_ff;
   assign rsp_chan.gate_type = code_ff;

endmodule

>>> rtl/truth_table_gate_classifier_core.sv
// Top level of the truth table gate classifier.
// The block takes one truth table bit per cycle, in minterm order, and after the last bit of
// each table (2^n bits, one bit for n of zero) delivers one gate code; all other bits give no
// item on the result channel. A bit passes an input register and the flag and counter logic,
// and the code of a table's last bit is loaded into the result register as that bit moves on
// out of the input register. Sustained rate is one bit per cycle; a result that
// waits to be taken only holds back the next table's last bit, which waits in the input
// register. The input count is read on the first bit of a table and clipped to MAX_INPUTS.
module truth_table_gate_classifier_core #(
   parameter int MAX_INPUTS = 10
) (
   input logic        clock,
   input logic        reset,
   ttgc_req_if.sink   req_chan,
   ttgc_rsp_if.source rsp_chan
);

   logic                 hold_valid;
   ttgc_pkg::item_type   hold_item;
   ttgc_pkg::result_type result;
   logic                 out_free;
   logic                 advance;
   logic                 load;

   // A held bit moves on unless it ends a table while the result register is still full.
   assign advance = hold_valid && (!result.last || out_free);
   assign load    = advance && result.last;

   ttgc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   ttgc_classify #(
      .MAX_INPUTS (MAX_INPUTS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .hold_item (hold_item),
      .advance   (advance),
      .result    (result)
   );

   ttgc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .gate_type (result.gate_type),
      .rsp_chan  (rsp_chan),
      .out_free  (out_free)
   );

endmodule

>>> rtl/ttgc_checker.sv
// Port-level checks for the truth table gate classifier, bound to the top level.
module ttgc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] gate_type
);

   // A stalled result keeps its code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(gate_type))
      else $error("stalled result changed");

   // Codes stay within the defined gate set.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> gate_type <= ttgc_pkg::GT_NONE)
      else $error("gate code out of range");

   // No result is shown right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // With the result register empty nothing can block the input side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no pending result");

   // An offered item is only held off while a result waits to be taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while the result side was free");

endmodule

bind truth_table_gate_classifier_core ttgc_checker u_ttgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .gate_type (rsp_chan.gate_type)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the truth table gate classifier core.
module testbench;

   localparam int MAX_TABLE_INPUTS = 10;
   localparam int RANDOM_ITEMS     = 300;
   localparam int MIN_TABLES       = 20;
   localparam int HOLD_CYCLES      = 200;
   localparam int DRAIN_CYCLES     = 10;

   // Function shapes the random tables are built from.
   typedef enum int {
      SHAPE_CONST0, SHAPE_CONST1, SHAPE_AND, SHAPE_OR, SHAPE_NAND,
      SHAPE_NOR, SHAPE_XOR, SHAPE_XNOR, SHAPE_NOISE
   } table_shape_type;

   // One directed item; a typed code is given only on the last bit of a table.
   typedef struct packed {
      logic [3:0]              num;
      logic                    value;
      logic                    typed;
      ttgc_pkg::gate_code_type code;
   } script_row_type;

   localparam int SCRIPT_LEN = 32;
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      // Zero-input tables.
      '{4'd0, 1'b0, 1'b1, ttgc_pkg::GT_C0}, '{4'd0, 1'b1, 1'b1, ttgc_pkg::GT_C1},
      // One-input tables: buffer, inverter, constant.
      '{4'd1, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd1, 1'b1, 1'b1, ttgc_pkg::GT_BUF},
      '{4'd1, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd1, 1'b0, 1'b1, ttgc_pkg::GT_NOT},
      '{4'd1, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd1, 1'b1, 1'b1, ttgc_pkg::GT_NONE},
      // Two-input and.
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b1, 1'b1, ttgc_pkg::GT_AND},
      // Two-input or, with the count changed after the first bit.
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd15, 1'b1, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd15, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd15, 1'b1, 1'b1, ttgc_pkg::GT_OR},
      // Two-input nand.
      '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b1, ttgc_pkg::GT_NAND},
      // Two-input nor.
      '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b1, ttgc_pkg::GT_NOR},
      // Two-input xor.
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b1, ttgc_pkg::GT_XOR},
      // Two-input xnor.
      '{4'd2, 1'b1, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE},
      '{4'd2, 1'b0, 1'b0, ttgc_pkg::GT_NONE}, '{4'd2, 1'b1, 1'b1, ttgc_pkg::GT_XNOR}
   };

   logic clock;
   logic reset;
   logic row_typed;
   ttgc_pkg::gate_code_type row_code;
   logic stall_request;
   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int error_count;

   ttgc_req_if req_bus();
   ttgc_rsp_if rsp_bus();

   truth_table_gate_classifier_core #(
      .MAX_INPUTS(MAX_TABLE_INPUTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // Free-running 100 MHz clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20_000_000;
      $display("testbench: errors");
      $finish;
   end

   // Predictor state for the table being received.
   logic [9:0]              minterm_pos_q;
   logic [3:0]              table_n_q;
   logic                    first_q;
   logic                    mid_zero_q;
   logic                    mid_one_q;
   logic                    xor_q;
   logic                    xnor_q;
   ttgc_pkg::gate_code_type gate_codes_due[$];

   // Names the gate from the end values and the flags of a finished table.
   function automatic ttgc_pkg::gate_code_type name_gate(input logic [3:0] n,
                                                         input logic v_first,
                                                         input logic v_last);
      if (n == 4'd0) begin
         return v_last ? ttgc_pkg::GT_C1 : ttgc_pkg::GT_C0;
      end
      if (n == 4'd1) begin
         if (v_first == v_last) begin
            return ttgc_pkg::GT_NONE;
         end
         return v_last ? ttgc_pkg::GT_BUF : ttgc_pkg::GT_NOT;
      end
      if (!v_first && v_last) begin
         if (!mid_zero_q) begin
            return ttgc_pkg::GT_OR;
         end
         if (!mid_one_q) begin
            return ttgc_pkg::GT_AND;
         end
      end
      if (v_first && !v_last) begin
         if (!mid_zero_q) begin
            return ttgc_pkg::GT_NAND;
         end
         if (!mid_one_q) begin
            return ttgc_pkg::GT_NOR;
         end
      end
      if (xor_q) begin
         return ttgc_pkg::GT_XOR;
      end
      return xnor_q ? ttgc_pkg::GT_XNOR : ttgc_pkg::GT_NONE;
   endfunction

   // Folds one table bit into the predictor; done is set on the last bit of a table.
   task automatic absorb_bit(input logic [3:0] num, input logic value, output logic done,
                             output ttgc_pkg::gate_code_type code);
      int last;
      code = ttgc_pkg::GT_NONE;
      if (minterm_pos_q == '0) begin
         table_n_q  = (num > MAX_TABLE_INPUTS) ? 4'(MAX_TABLE_INPUTS) : num;
         first_q    = value;
         mid_zero_q = 1'b0;
         mid_one_q  = 1'b0;
         xor_q      = 1'b1;
         xnor_q     = 1'b1;
      end
      last = (1 << table_n_q) - 1;
      if (minterm_pos_q != '0 && int'(minterm_pos_q) != last) begin
         if (value) begin
            mid_one_q = 1'b1;
         end else begin
            mid_zero_q = 1'b1;
         end
      end
      if (value != ^minterm_pos_q) begin
         xor_q = 1'b0;
      end else begin
         xnor_q = 1'b0;
      end
      done = (int'(minterm_pos_q) == last);
      if (done) begin
         code = name_gate(table_n_q, first_q, value);
         minterm_pos_q = '0;
      end else begin
         minterm_pos_q = minterm_pos_q + 10'd1;
      end
   endtask

   // Checks each taken result and predicts from each accepted item.
   always @(posedge clock) begin
      logic                    done;
      ttgc_pkg::gate_code_type code;
      ttgc_pkg::gate_code_type due;
      if (reset) begin
         minterm_pos_q = '0;
         table_n_q     = '0;
         first_q       = 1'b0;
         mid_zero_q    = 1'b0;
         mid_one_q     = 1'b0;
         xor_q         = 1'b1;
         xnor_q        = 1'b1;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (gate_codes_due.size() == 0) begin
               $error("gate_type: unexpected result %0d", rsp_bus.gate_type);
               error_count++;
            end else begin
               due = gate_codes_due.pop_front();
               if (rsp_bus.gate_type !== due) begin
                  $error("gate_type mismatch: expected %0d, actual %0d", due,
                         rsp_bus.gate_type);
                  error_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            absorb_bit(req_bus.num_inputs, req_bus.truth_bit, done, code);
            if (done) begin
               gate_codes_due.push_back(row_typed ? row_code : code);
            end
         end
      end
   end

   // Result side: random back-pressure, plus one long hold-off on request.
   initial begin : receiver
      int   hold_left;
      logic hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one item and waits until it is accepted.
   task automatic send_bit(input logic [3:0] num, input logic value, input logic typed,
                           input ttgc_pkg::gate_code_type code);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.num_inputs <= num;
      req_bus.truth_bit  <= value;
      row_typed          <= typed;
      row_code           <= code;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   // Sends a whole table of the given shape, optionally with one bit inverted.
   task automatic send_table(input logic [3:0] num_field, input table_shape_type shape,
                             input logic flip);
      int   last;
      int   flip_at;
      logic value;
      last    = (1 << ((num_field > MAX_TABLE_INPUTS) ? MAX_TABLE_INPUTS : num_field)) - 1;
      flip_at = flip ? int'($urandom_range(last)) : -1;
      for (int m = 0; m <= last; m++) begin
         case (shape)
            SHAPE_CONST0: value = 1'b0;
            SHAPE_CONST1: value = 1'b1;
            SHAPE_AND:    value = (m == last);
            SHAPE_OR:     value = (m != 0);
            SHAPE_NAND:   value = (m != last);
            SHAPE_NOR:    value = (m == 0);
            SHAPE_XOR:    value = ^m;
            SHAPE_XNOR:   value = ~^m;
            default:      value = 1'($urandom_range(1));
         endcase
         if (m == flip_at) begin
            value = ~value;
         end
         // The count is ignored after the first bit, so it is noise there.
         send_bit((m == 0) ? num_field : 4'($urandom_range(15)), value, 1'b0,
                  ttgc_pkg::GT_NONE);
      end
   endtask

   // Mostly small tables; a few mid-sized ones and rare big ones.
   function automatic logic [3:0] pick_input_count();
      int r;
      r = $urandom_range(99);
      if (r < 18) begin
         return 4'd0;
      end else if (r < 36) begin
         return 4'd1;
      end else if (r < 64) begin
         return 4'd2;
      end else if (r < 80) begin
         return 4'd3;
      end else if (r < 93) begin
         return 4'(4 + $urandom_range(1));
      end else if (r < 99) begin
         return 4'(6 + $urandom_range(1));
      end
      return 4'(8 + $urandom_range(1));
   endfunction

   // Stimulus: reset, directed tables, a back-pressure burst, random tables, then a clipped table.
   initial begin
      int random_start;
      int tables;
      error_count   = 0;
      items_sent    = 0;
      send_idle_pct = 24;
      recv_idle_pct = 56;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.num_inputs <= '0;
      req_bus.truth_bit  <= 1'b0;
      row_typed          <= 1'b0;
      row_code           <= ttgc_pkg::GT_NONE;
      stall_request      <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_bit(SCRIPT[i].num, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].code);
      end

      // Zero-input tables give a result per item, so a held receiver fills the block.
      send_idle_pct = 0;
      stall_request <= 1'b1;
      for (int i = 0; i < 16; i++) begin
         send_bit(4'd0, 1'($urandom_range(1)), 1'b0, ttgc_pkg::GT_NONE);
      end

      random_start = items_sent;
      tables       = 0;
      while (items_sent - random_start < RANDOM_ITEMS || tables < MIN_TABLES) begin
         if (items_sent - random_start < RANDOM_ITEMS / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 56;
         end else if (items_sent - random_start < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 56;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_table(pick_input_count(), table_shape_type'($urandom_range(SHAPE_NOISE)),
                    ($urandom_range(99) < 30));
         tables++;
      end

      // A count above the maximum is clipped to it, which also runs the longest table.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_table(4'(11 + $urandom_range(4)), SHAPE_XNOR, 1'b0);
      req_bus.valid <= 1'b0;

      while (gate_codes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

>>> truth_table_gate_classifier_core.f
rtl/ttgc_pkg.sv
rtl/ttgc_if.sv
rtl/ttgc_in_stage.sv
rtl/ttgc_classify.sv
rtl/ttgc_out_reg.sv
rtl/truth_table_gate_classifier_core.sv
rtl/ttgc_checker.sv
verif/testbench.sv
